FILE: hw/rtl/kald_pkg.sv
package kald_pkg;

    // fixed field widths
    localparam int ZERO_W     = 10;
    localparam int STEP_W     = 8;
    localparam int HOLD_W     = 16;
    localparam int MS_W       = 32;
    localparam int CH_W       = 2;
    localparam int MULT_W     = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // knob layout
    localparam int NUM_OFFSETS   = 2;
    localparam int NUM_TIMERS    = 6;
    localparam int TMR_AW        = 3;
    localparam int TRIG_TMR_BASE = 4;
    localparam int LEVEL_RESET   = 500;

    // acceleration thresholds in ms
    localparam logic [MS_W-1:0] ACCEL_T1 = 32'd75;
    localparam logic [MS_W-1:0] ACCEL_T2 = 32'd50;
    localparam logic [MS_W-1:0] ACCEL_T3 = 32'd25;

    // configuration reset values
    localparam logic [ZERO_W-1:0] ZERO_RESET = 10'd500;
    localparam logic [STEP_W-1:0] STEP_RESET = 8'd1;
    localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd500;

    typedef logic [MS_W-1:0] t_ms;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ZERO_VALUE = 2'd0,
        CFG_STEP_SIZE  = 2'd1,
        CFG_HOLD_MS    = 2'd2
    } t_cfg_idx;

    // timer memory write port
    typedef struct packed {
        logic              en;
        logic [TMR_AW-1:0] addr;
        t_ms               data;
    } t_tmr_wr;

endpackage

FILE: hw/rtl/kald_ifs.sv
interface kald_in_if import kald_pkg::*; ();
    logic            valid;
    logic            ready;
    logic            func;
    logic [CH_W-1:0] channel;
    logic            direction;
    t_ms             now_ms;

    modport source (output valid, func, channel, direction, now_ms, input ready);
    modport sink   (input valid, func, channel, direction, now_ms, output ready);
endinterface

interface kald_out_if import kald_pkg::*; #(parameter int LEVEL_BITS = 10) ();
    logic                  valid;
    logic                  ready;
    logic [LEVEL_BITS-1:0] new_level;
    logic                  accepted;
    logic                  knob_kind;
    logic [CH_W-1:0]       knob_channel;

    modport source (output valid, new_level, accepted, knob_kind, knob_channel, input ready);
    modport sink   (input valid, new_level, accepted, knob_kind, knob_channel, output ready);
endinterface

interface kald_cfg_if import kald_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: hw/rtl/kald_ram.sv
module kald_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // single write port, registered read returns old data on collision
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hw/rtl/kald_timer.sv
module kald_timer import kald_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_rd_en,
    input  logic [TMR_AW-1:0] i_rd_addr,
    input  t_tmr_wr           i_wr,
    input  t_ms               i_now,
    output logic [MULT_W-1:0] o_mult
);

    logic [NUM_TIMERS-1:0] r_vld;
    logic                  r_rd_vld;
    logic [TMR_AW-1:0]     r_rd_addr;
    t_tmr_wr               r_last;
    t_ms                   ram_q;
    t_ms                   last_t;
    t_ms                   delta;

    kald_ram #(
        .WIDTH (MS_W),
        .DEPTH (NUM_TIMERS)
    ) u_tmr_ram (
        .i_clk     (i_clk),
        .i_wr_en   (i_wr.en),
        .i_wr_addr (i_wr.addr),
        .i_wr_data (i_wr.data),
        .i_rd_en   (i_rd_en),
        .i_rd_addr (i_rd_addr),
        .o_rd_data (ram_q)
    );

    // entry valid bits, last write kept for forwarding
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
            r_last   <= '0;
        end else begin
            if (i_wr.en) begin
                r_vld[i_wr.addr] <= 1'b1;
                r_last           <= i_wr;
            end
            if (i_rd_en) begin
                r_rd_vld <= (i_rd_addr < TMR_AW'(NUM_TIMERS)) ? r_vld[i_rd_addr] : 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_addr <= i_rd_addr;
        end
    end

    // latest write wins over the read data, unwritten entries read as zero
    always_comb begin
        if (r_last.en && (r_last.addr == r_rd_addr)) begin
            last_t = r_last.data;
        end else if (r_rd_vld) begin
            last_t = ram_q;
        end else begin
            last_t = '0;
        end
    end

    assign delta = i_now - last_t;

    // faster turns give a larger multiplier
    always_comb begin
        priority if (delta > ACCEL_T1) begin
            o_mult = 3'd1;
        end else if (delta > ACCEL_T2) begin
            o_mult = 3'd2;
        end else if (delta > ACCEL_T3) begin
            o_mult = 3'd3;
        end else begin
            o_mult = 3'd4;
        end
    end

endmodule

FILE: hw/rtl/kald_hold.sv
module kald_hold import kald_pkg::*; #(
    parameter int NUM_CHANNELS = 3
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [CH_W-1:0]   i_ch,
    input  logic              i_cand_zero,
    input  t_ms               i_now,
    input  logic [HOLD_W-1:0] i_hold_ms,
    input  logic              i_commit,
    output logic              o_ok
);

    localparam int HAW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    logic [NUM_CHANNELS-1:0] r_armed;
    t_ms                     r_start [NUM_CHANNELS];
    logic [HAW-1:0]          idx;
    t_ms                     age;
    logic                    expired;

    assign idx     = HAW'(i_ch);
    assign age     = i_now - r_start[idx];
    assign expired = age > MS_W'(i_hold_ms);
    assign o_ok    = i_cand_zero || !r_armed[idx] || expired;

    // arm on landing at the centre, release once the hold has run out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed <= '0;
        end else if (i_commit) begin
            if (i_cand_zero) begin
                r_armed[idx] <= 1'b1;
            end else if (r_armed[idx] && expired) begin
                r_armed[idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_commit && i_cand_zero) begin
            r_start[idx] <= i_now;
        end
    end

endmodule

FILE: hw/rtl/knob_accelerated_level_detent_core.sv
// channel   dir  signals                                   meaning
// i_turn    in   valid ready func channel direction now_ms  one detent turn
// o_result  out  valid ready new_level accepted knob_*     level after the turn
// i_cfg     in   valid ready index data                    register write, always ready
//
// one turn per cycle sustained while o_result.ready keeps up; a result passes stage 1, stage 2 and the output register
// pipeline: read level and timer memories, accel select and timer write, level update
// reset clears config to defaults; valid bits make unwritten entries read as reset values
// output stall backs up through the stages to i_turn.ready

module knob_accelerated_level_detent_core import kald_pkg::*; #(
    parameter int NUM_CHANNELS = 3,
    parameter int LEVEL_BITS   = 10
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    kald_in_if.sink        i_turn,
    kald_out_if.source     o_result,
    kald_cfg_if.sink       i_cfg
);

    localparam int NUM_LEVELS = NUM_OFFSETS + NUM_CHANNELS;
    localparam int LAW        = $clog2(NUM_LEVELS);
    localparam int SW         = LEVEL_BITS + 12;
    localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = '1;
    localparam logic [LEVEL_BITS-1:0] LVL_RST   = LEVEL_BITS'(LEVEL_RESET);
    localparam logic [CH_W:0] TRIG_LIMIT =
        (NUM_CHANNELS > 4) ? (CH_W+1)'(4) : (CH_W+1)'(NUM_CHANNELS);
    localparam logic [CH_W:0] OFS_LIMIT = (CH_W+1)'(NUM_OFFSETS);

    typedef struct packed {
        logic                  en;
        logic [LAW-1:0]        addr;
        logic [LEVEL_BITS-1:0] data;
    } t_lvl_wr;

    // configuration registers
    logic [ZERO_W-1:0] r_zero;
    logic [STEP_W-1:0] r_step;
    logic [HOLD_W-1:0] r_hold;

    // stage 1
    logic              r_s1_valid;
    logic              r_s1_func;
    logic [CH_W-1:0]   r_s1_ch;
    logic              r_s1_dir;
    t_ms               r_s1_now;
    logic [LAW-1:0]    r_s1_lidx;
    logic [TMR_AW-1:0] r_s1_tidx;
    logic              r_s1_inrange;
    logic              r_s1_lvl_vld;

    // stage 2
    logic                  r_s2_valid;
    logic                  r_s2_func;
    logic [CH_W-1:0]       r_s2_ch;
    logic                  r_s2_dir;
    t_ms                   r_s2_now;
    logic [LAW-1:0]        r_s2_lidx;
    logic                  r_s2_inrange;
    logic [MULT_W-1:0]     r_s2_mult;
    logic [LEVEL_BITS-1:0] r_s2_old;

    // output register
    logic                  r_out_valid;
    logic [LEVEL_BITS-1:0] r_out_level;
    logic                  r_out_acc;
    logic                  r_out_kind;
    logic [CH_W-1:0]       r_out_ch;

    // level memory bookkeeping
    logic [NUM_LEVELS-1:0] r_lvl_vld;
    t_lvl_wr               r_lw1;
    t_lvl_wr               r_lw2;

    logic                  in_go;
    logic                  s1_go;
    logic                  s2_go;
    logic                  in_range;
    logic [LAW-1:0]        in_lidx;
    logic [TMR_AW-1:0]     in_tidx;
    logic [LEVEL_BITS-1:0] lvl_q;
    logic [LEVEL_BITS-1:0] s1_old;
    logic [MULT_W-1:0]     s1_mult;
    t_tmr_wr               tmr_wr;
    logic [LEVEL_BITS-1:0] old2;
    logic [STEP_W+MULT_W-1:0] prod;
    logic signed [SW-1:0]  old_s;
    logic signed [SW-1:0]  prod_s;
    logic signed [SW-1:0]  z_s;
    logic signed [SW-1:0]  sum;
    logic signed [SW-1:0]  snap;
    logic signed [SW-1:0]  sat;
    logic [LEVEL_BITS-1:0] cand;
    logic                  cand_zero;
    logic                  hold_ok;
    logic                  commit;
    logic                  lvl_we;
    t_lvl_wr               lvl_wr;

    // handshake and stage advance
    assign s2_go          = r_s2_valid && (!r_out_valid || o_result.ready);
    assign s1_go          = r_s1_valid && (!r_s2_valid || s2_go);
    assign i_turn.ready   = !r_s1_valid || s1_go;
    assign in_go          = i_turn.valid && i_turn.ready;
    assign i_cfg.ready    = 1'b1;

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero <= ZERO_RESET;
            r_step <= STEP_RESET;
            r_hold <= HOLD_RESET;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_ZERO_VALUE: r_zero <= i_cfg.data[ZERO_W-1:0];
                CFG_STEP_SIZE:  r_step <= i_cfg.data[STEP_W-1:0];
                CFG_HOLD_MS:    r_hold <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // input decode: level entry and timer entry
    always_comb begin
        if (i_turn.func) begin
            in_range = {1'b0, i_turn.channel} < TRIG_LIMIT;
            in_lidx  = LAW'(NUM_OFFSETS) + LAW'(i_turn.channel);
            in_tidx  = TMR_AW'(TRIG_TMR_BASE) | TMR_AW'(i_turn.direction);
        end else begin
            in_range = {1'b0, i_turn.channel} < OFS_LIMIT;
            in_lidx  = LAW'(i_turn.channel);
            in_tidx  = {1'b0, i_turn.channel[0], i_turn.direction};
        end
    end

    kald_ram #(
        .WIDTH (LEVEL_BITS),
        .DEPTH (NUM_LEVELS)
    ) u_lvl_ram (
        .i_clk     (i_clk),
        .i_wr_en   (lvl_wr.en),
        .i_wr_addr (lvl_wr.addr),
        .i_wr_data (lvl_wr.data),
        .i_rd_en   (in_go),
        .i_rd_addr (in_lidx),
        .o_rd_data (lvl_q)
    );

    assign tmr_wr.en   = s1_go && r_s1_inrange;
    assign tmr_wr.addr = r_s1_tidx;
    assign tmr_wr.data = r_s1_now;

    kald_timer u_timer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_go),
        .i_rd_addr (in_tidx),
        .i_wr      (tmr_wr),
        .i_now     (r_s1_now),
        .o_mult    (s1_mult)
    );

    // stage 1 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (in_go) begin
            r_s1_valid <= 1'b1;
        end else if (s1_go) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_go) begin
            r_s1_func    <= i_turn.func;
            r_s1_ch      <= i_turn.channel;
            r_s1_dir     <= i_turn.direction;
            r_s1_now     <= i_turn.now_ms;
            r_s1_lidx    <= in_lidx;
            r_s1_tidx    <= in_tidx;
            r_s1_inrange <= in_range;
            r_s1_lvl_vld <= (in_lidx < LAW'(NUM_LEVELS)) ? r_lvl_vld[in_lidx] : 1'b0;
        end
    end

    // level forwarding from the two latest writes
    always_comb begin
        if (r_lw1.en && (r_lw1.addr == r_s1_lidx)) begin
            s1_old = r_lw1.data;
        end else if (r_lw2.en && (r_lw2.addr == r_s1_lidx)) begin
            s1_old = r_lw2.data;
        end else if (r_s1_lvl_vld) begin
            s1_old = lvl_q;
        end else begin
            s1_old = LVL_RST;
        end
    end

    // stage 2 registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s1_go) begin
            r_s2_valid <= 1'b1;
        end else if (s2_go) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_go) begin
            r_s2_func    <= r_s1_func;
            r_s2_ch      <= r_s1_ch;
            r_s2_dir     <= r_s1_dir;
            r_s2_now     <= r_s1_now;
            r_s2_lidx    <= r_s1_lidx;
            r_s2_inrange <= r_s1_inrange;
            r_s2_mult    <= s1_mult;
            r_s2_old     <= s1_old;
        end
    end

    // a write on the edge that moved the item into stage 2
    assign old2 = (r_lw1.en && (r_lw1.addr == r_s2_lidx)) ? r_lw1.data : r_s2_old;

    // accelerated step, centre snap, saturation
    assign prod   = (STEP_W+MULT_W)'(r_step) * (STEP_W+MULT_W)'(r_s2_mult);
    assign old_s  = SW'(old2);
    assign prod_s = SW'(prod);
    assign z_s    = SW'(r_zero);
    assign sum    = r_s2_dir ? (old_s + prod_s) : (old_s - prod_s);

    always_comb begin
        if (((old_s > z_s) && (sum < z_s)) || ((old_s < z_s) && (sum > z_s))) begin
            snap = z_s;
        end else begin
            snap = sum;
        end
        priority if (snap < 0) begin
            sat = '0;
        end else if (snap > SW'(LEVEL_MAX)) begin
            sat = SW'(LEVEL_MAX);
        end else begin
            sat = snap;
        end
    end

    assign cand      = sat[LEVEL_BITS-1:0];
    assign cand_zero = (sat == z_s);
    assign commit    = s2_go && r_s2_inrange;

    kald_hold #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_hold (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ch        (r_s2_ch),
        .i_cand_zero (cand_zero),
        .i_now       (r_s2_now),
        .i_hold_ms   (r_hold),
        .i_commit    (commit),
        .o_ok        (hold_ok)
    );

    assign lvl_we      = commit && hold_ok;
    assign lvl_wr.en   = lvl_we;
    assign lvl_wr.addr = r_s2_lidx;
    assign lvl_wr.data = cand;

    // level valid bits and write history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lvl_vld <= '0;
            r_lw1     <= '0;
            r_lw2     <= '0;
        end else if (lvl_we) begin
            r_lvl_vld[r_s2_lidx] <= 1'b1;
            r_lw1                <= lvl_wr;
            r_lw2                <= r_lw1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_go) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_go) begin
            r_out_kind <= r_s2_func;
            r_out_ch   <= r_s2_ch;
            r_out_acc  <= r_s2_inrange && hold_ok;
            if (!r_s2_inrange) begin
                r_out_level <= '0;
            end else if (hold_ok) begin
                r_out_level <= cand;
            end else begin
                r_out_level <= old2;
            end
        end
    end

    assign o_result.valid        = r_out_valid;
    assign o_result.new_level    = r_out_level;
    assign o_result.accepted     = r_out_acc;
    assign o_result.knob_kind    = r_out_kind;
    assign o_result.knob_channel = r_out_ch;

    a_in_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_go |=> r_s1_valid)
        else $error("accepted turn did not reach stage 1");

    a_s2_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s2_go |=> r_out_valid)
        else $error("stage 2 advanced without a result");

    a_wr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lvl_we |-> (s2_go && r_s2_inrange))
        else $error("level write for an ignored turn");

    a_wr_history: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lvl_we |=> (r_lw1.en && (r_lw1.data == $past(cand))))
        else $error("write history missed a level write");

endmodule

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import kald_pkg::*;

    localparam int NUM_CH       = 3;
    localparam int LVL_W        = 10;
    localparam int LVL_MAX      = (1 << LVL_W) - 1;
    localparam int NUM_LEVELS   = NUM_OFFSETS + NUM_CH;
    localparam int STALL_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 10;
    localparam int ITEMS_PER_PHASE = 310;
    localparam int TURNS_PER_CFG   = 64;

    typedef struct packed {
        logic            func;
        logic [CH_W-1:0] channel;
        logic            direction;
        t_ms             now_ms;
    } turn_t;

    typedef struct packed {
        logic [LVL_W-1:0] new_level;
        logic             accepted;
        logic             knob_kind;
        logic [CH_W-1:0]  knob_channel;
    } level_res_t;

    logic i_clk;
    logic i_rst_n;

    kald_in_if                         turn_if ();
    kald_out_if #(.LEVEL_BITS(LVL_W))  res_if ();
    kald_cfg_if                        cfg_if ();

    knob_accelerated_level_detent_core #(
        .NUM_CHANNELS(NUM_CH),
        .LEVEL_BITS  (LVL_W)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_turn  (turn_if),
        .o_result(res_if),
        .i_cfg   (cfg_if)
    );

    // shadow copy of the knob state and registers
    logic [ZERO_W-1:0] zero_q;
    logic [STEP_W-1:0] step_q;
    logic [HOLD_W-1:0] hold_q;
    logic [LVL_W-1:0]  level_q      [NUM_LEVELS];
    t_ms               last_turn_q  [NUM_TIMERS];
    t_ms               hold_start_q [NUM_CH];
    logic              hold_armed_q [NUM_CH];

    level_res_t expected_levels[$];
    level_res_t exp_r;
    int         errors;
    int         send_idle_pct;
    int         recv_idle_pct;
    int         quiet_cycles;
    t_ms        ms_now;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // level after one detent, updating the shadow state
    function automatic level_res_t predict_turn(input turn_t t);
        level_res_t r;
        int         lvl_idx;
        int         tmr_idx;
        int         mult;
        int         old_lvl;
        int         cand;
        int         z;
        int         step_i;
        t_ms        gap;
        t_ms        age;
        logic       pass;
        r.knob_kind    = t.func;
        r.knob_channel = t.channel;
        r.new_level    = '0;
        r.accepted     = 1'b0;
        if ((!t.func && t.channel >= NUM_OFFSETS) || (t.func && t.channel >= NUM_CH))
            return r;
        if (t.func) begin
            lvl_idx = NUM_OFFSETS + int'(t.channel);
            tmr_idx = TRIG_TMR_BASE + int'(t.direction);
        end else begin
            lvl_idx = int'(t.channel);
            tmr_idx = 2 * int'(t.channel) + int'(t.direction);
        end

        // acceleration from the interval since the same offset knob and direction, or any trigger in that direction
        gap = t.now_ms - last_turn_q[tmr_idx];
        last_turn_q[tmr_idx] = t.now_ms;
        if (gap > ACCEL_T1) mult = 1;
        else if (gap > ACCEL_T2) mult = 2;
        else if (gap > ACCEL_T3) mult = 3;
        else mult = 4;

        // step, snap to centre on crossing, saturate
        old_lvl = int'(level_q[lvl_idx]);
        z       = int'(zero_q);
        step_i  = int'(step_q);
        cand    = t.direction ? old_lvl + step_i * mult : old_lvl - step_i * mult;
        if ((old_lvl > z && cand < z) || (old_lvl < z && cand > z)) cand = z;
        if (cand < 0) cand = 0;
        if (cand > LVL_MAX) cand = LVL_MAX;

        // centre hold, shared by offset and trigger of the same index
        age = t.now_ms - hold_start_q[t.channel];
        if (cand == z) begin
            hold_start_q[t.channel] = t.now_ms;
            hold_armed_q[t.channel] = 1'b1;
            pass = 1'b1;
        end else if (!hold_armed_q[t.channel]) begin
            pass = 1'b1;
        end else if (age > t_ms'(hold_q)) begin
            hold_armed_q[t.channel] = 1'b0;
            hold_start_q[t.channel] = '0;
            pass = 1'b1;
        end else begin
            pass = 1'b0;
        end
        if (pass) level_q[lvl_idx] = cand[LVL_W-1:0];
        r.new_level = level_q[lvl_idx];
        r.accepted  = pass;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (expected_levels.size() == 0) begin
                errors++;
                $display("%0t: result with none expected, expected nothing, actual level %0d",
                         $time, res_if.new_level);
            end else begin
                exp_r = expected_levels.pop_front();
                check_field("new_level", 32'(exp_r.new_level), 32'(res_if.new_level));
                check_field("accepted", 32'(exp_r.accepted), 32'(res_if.accepted));
                check_field("knob_kind", 32'(exp_r.knob_kind), 32'(res_if.knob_kind));
                check_field("knob_channel", 32'(exp_r.knob_channel),
                            32'(res_if.knob_channel));
            end
        end
    end

    // result backpressure
    always @(negedge i_clk) begin
        res_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((turn_if.valid && turn_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // one turn transfer, with random sender gaps
    task automatic send_turn(input turn_t t);
        while ($urandom_range(99) < send_idle_pct) begin
            turn_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        turn_if.valid     <= 1'b1;
        turn_if.func      <= t.func;
        turn_if.channel   <= t.channel;
        turn_if.direction <= t.direction;
        turn_if.now_ms    <= t.now_ms;
        @(posedge i_clk);
        while (!turn_if.ready) @(posedge i_clk);
        expected_levels.push_back(predict_turn(t));
        @(negedge i_clk);
    endtask

    task automatic turn_after(input logic f, input int ch, input logic dir, input t_ms gap);
        turn_t t;
        ms_now      = ms_now + gap;
        t.func      = f;
        t.channel   = ch[CH_W-1:0];
        t.direction = dir;
        t.now_ms    = ms_now;
        send_turn(t);
    endtask

    task automatic wait_idle();
        turn_if.valid <= 1'b0;
        while (expected_levels.size() != 0) @(negedge i_clk);
    endtask

    // register write once all results are back
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        wait_idle();
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        @(posedge i_clk);
        while (!cfg_if.ready) @(posedge i_clk);
        case (idx)
            CFG_ZERO_VALUE: zero_q = val[ZERO_W-1:0];
            CFG_STEP_SIZE:  step_q = val[STEP_W-1:0];
            CFG_HOLD_MS:    hold_q = val[HOLD_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_if.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // first turn measures from the cleared timer
    task automatic test_first_turn();
        turn_after(1'b0, 0, 1'b1, 5);
    endtask

    // out-of-range channels are echoed with no state change
    task automatic test_channel_range();
        turn_after(1'b0, 2, 1'b0, 100);
        turn_after(1'b0, 3, 1'b1, 100);
        turn_after(1'b1, 3, 1'b1, 100);
    endtask

    // multiplier thresholds on both sides of 75, 50 and 25 ms
    task automatic test_accel_steps();
        turn_after(1'b0, 1, 1'b1, 76);
        turn_after(1'b0, 1, 1'b1, 75);
        turn_after(1'b0, 1, 1'b1, 51);
        turn_after(1'b0, 1, 1'b1, 50);
        turn_after(1'b0, 1, 1'b1, 26);
        turn_after(1'b0, 1, 1'b1, 25);
    endtask

    // snap across the centre, then hold refusal and expiry
    task automatic test_detent_hold();
        write_reg(CFG_STEP_SIZE, 16'd100);
        turn_after(1'b1, 0, 1'b1, 100);
        turn_after(1'b1, 0, 1'b1, 100);
        turn_after(1'b1, 0, 1'b0, 100);
        turn_after(1'b1, 0, 1'b0, 30);
        // offset 0 shares the hold of index 0
        turn_after(1'b0, 0, 1'b1, 100);
        // age equal to hold_ms still refused, one more ms releases
        turn_after(1'b1, 0, 1'b1, 400);
        turn_after(1'b1, 0, 1'b1, 1);
    endtask

    // saturation at both ends of the level range
    task automatic test_saturation();
        write_reg(CFG_ZERO_VALUE, 16'd0);
        write_reg(CFG_STEP_SIZE, 16'd255);
        turn_after(1'b0, 1, 1'b1, 10);
        write_reg(CFG_ZERO_VALUE, 16'd1023);
        turn_after(1'b0, 1, 1'b0, 200);
        turn_after(1'b0, 1, 1'b0, 10);
    endtask

    // interval taken across the 32-bit time wrap
    task automatic test_time_wrap();
        ms_now = 32'hFFFF_FFF0;
        turn_after(1'b1, 2, 1'b1, 0);
        turn_after(1'b1, 2, 1'b1, 32);
    endtask

    // zero step at the centre re-arms the hold
    task automatic test_zero_step();
        write_reg(CFG_ZERO_VALUE, 16'(level_q[0]));
        write_reg(CFG_STEP_SIZE, 16'd0);
        turn_after(1'b0, 0, 1'b1, 10);
    endtask

    // bursts of turns with random intervals, mostly steered toward the centre
    task automatic test_random_turns(input int n_items, input int send_pct, input int recv_pct);
        turn_t                 t;
        int                    sent;
        int                    seg;
        int                    burst;
        logic [ZERO_W-1:0]     zero_v;
        logic [STEP_W-1:0]     step_v;
        logic [HOLD_W-1:0]     hold_v;
        t_ms                   gap;
        logic                  in_range;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        seg  = 0;
        while (sent < n_items) begin
            // new register setting, extremes first
            if (sent >= seg * TURNS_PER_CFG) begin
                case (seg % 4)
                    0: begin
                        zero_v = '0;
                        step_v = 8'd1;
                        hold_v = '0;
                    end
                    1: begin
                        zero_v = 10'd1023;
                        step_v = 8'd255;
                        hold_v = 16'hFFFF;
                    end
                    2: begin
                        zero_v = ZERO_W'($urandom_range(1023));
                        step_v = STEP_W'($urandom_range(1, 16));
                        hold_v = HOLD_W'($urandom_range(300));
                    end
                    default: begin
                        zero_v = ZERO_W'($urandom_range(300, 700));
                        step_v = ($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
                        hold_v = HOLD_W'($urandom_range(30, 150));
                    end
                endcase
                write_reg(CFG_ZERO_VALUE, 16'(zero_v));
                write_reg(CFG_STEP_SIZE, 16'(step_v));
                write_reg(CFG_HOLD_MS, hold_v);
                seg++;
            end

            // pick a knob, mostly a valid one
            t.func = 1'($urandom_range(1));
            in_range = ($urandom_range(19) != 0);
            if (!in_range)
                t.channel = t.func ? 2'd3 : 2'($urandom_range(2, 3));
            else
                t.channel = t.func ? 2'($urandom_range(NUM_CH - 1))
                                   : 2'($urandom_range(NUM_OFFSETS - 1));
            if (in_range && $urandom_range(9) < 6)
                t.direction = (level_q[t.func ? NUM_OFFSETS + t.channel : t.channel] > zero_q)
                              ? 1'b0 : 1'b1;
            else
                t.direction = 1'($urandom_range(1));

            burst = $urandom_range(1, 8);
            repeat (burst) begin
                case ($urandom_range(9))
                    0, 1, 2: gap = $urandom_range(25);
                    3:       gap = $urandom_range(26, 50);
                    4:       gap = $urandom_range(51, 75);
                    5, 6:    gap = $urandom_range(76, 400);
                    7, 8:    gap = t_ms'(hold_q) + $urandom_range(4) - 2;
                    default: gap = $urandom();
                endcase
                ms_now   = ms_now + gap;
                t.now_ms = ms_now;
                send_turn(t);
                sent++;
            end
        end
    endtask

    // test sequence
    initial begin
        i_rst_n           = 1'b0;
        turn_if.valid     = 1'b0;
        turn_if.func      = 1'b0;
        turn_if.channel   = '0;
        turn_if.direction = 1'b0;
        turn_if.now_ms    = '0;
        res_if.ready      = 1'b0;
        cfg_if.valid      = 1'b0;
        cfg_if.index      = CFG_ZERO_VALUE;
        cfg_if.data       = '0;
        errors            = 0;
        quiet_cycles      = 0;
        ms_now            = '0;
        send_idle_pct     = 8;
        recv_idle_pct     = 50;
        zero_q = ZERO_RESET;
        step_q = STEP_RESET;
        hold_q = HOLD_RESET;
        for (int i = 0; i < NUM_LEVELS; i++) level_q[i] = LVL_W'(LEVEL_RESET);
        for (int i = 0; i < NUM_TIMERS; i++) last_turn_q[i] = '0;
        for (int i = 0; i < NUM_CH; i++) begin
            hold_start_q[i] = '0;
            hold_armed_q[i] = 1'b0;
        end

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_first_turn();
        test_channel_range();
        test_accel_steps();
        test_detent_hold();
        test_saturation();
        test_time_wrap();
        test_zero_step();
        test_random_turns(ITEMS_PER_PHASE, 8, 50);
        test_random_turns(ITEMS_PER_PHASE, 50, 8);
        test_random_turns(ITEMS_PER_PHASE, 0, 0);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

FILE: files.f
hw/rtl/kald_pkg.sv
hw/rtl/kald_ifs.sv
hw/rtl/kald_ram.sv
hw/rtl/kald_timer.sv
hw/rtl/kald_hold.sv
hw/rtl/knob_accelerated_level_detent_core.sv
sim/tb_top.sv
